// ===== design/dswpg_pkg.sv =====
// dswpg_pkg: shared types and constants for the dual square-wave generator
// with pwm gating and work-time countdown
// no dependencies
package dswpg_pkg;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned LEVEL_W  = 4;
    localparam int unsigned SECS_W   = 16;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 24;

    typedef enum logic [KIND_W-1:0] {
        KIND_SECOND = 2'd0,
        KIND_WAVE   = 2'd1,
        KIND_PWM    = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_PERIOD = 3'd0,
        REG_SOUND_PERIOD = 3'd1,
        REG_LIGHT_LEVEL  = 3'd2,
        REG_SOUND_LEVEL  = 3'd3,
        REG_WORK_SECONDS = 3'd4
    } t_reg_idx;

    localparam logic [PERIOD_W-1:0] RST_PERIOD = 16'd456;
    localparam logic [LEVEL_W-1:0]  RST_LEVEL  = 4'd10;
    localparam logic [SECS_W-1:0]   RST_SECS   = 16'd3600;

    // one result word
    typedef struct packed {
        logic [SECS_W-1:0] seconds_left;
        logic              standby;
        logic              sound_pin;
        logic              light_pin;
    } t_result;

endpackage

// ===== design/dswpg_wave.sv =====
// dswpg_wave: one square-wave phase counter with its wave level register
// depends on dswpg_pkg
module dswpg_wave (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [dswpg_pkg::PERIOD_W-1:0] i_period,
    output logic                          o_wave
);

    logic [dswpg_pkg::PERIOD_W-1:0] r_phase;
    logic [dswpg_pkg::PERIOD_W-1:0] n_phase;
    logic                           r_wave;
    logic                           n_wave;
    logic [dswpg_pkg::PERIOD_W-1:0] w_inc;

    always_comb begin
        w_inc   = r_phase + dswpg_pkg::PERIOD_W'(1);
        n_phase = r_phase;
        n_wave  = r_wave;
        if (i_en) begin
            // high in the first half, wrap once the period is reached or passed
            n_wave  = (w_inc <= (i_period >> 1));
            n_phase = (w_inc >= i_period) ? '0 : w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_wave  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_wave  <= n_wave;
        end
    end

    assign o_wave = r_wave;

endmodule

// ===== design/dual_square_wave_with_pwm_gating_core.sv =====
// dual_square_wave_with_pwm_gating_core: top level of the light and sound
// square-wave generator with pwm gating and work-time countdown
// depends on dswpg_pkg and dswpg_wave
//
// Usage
// - input stream: one word per tick, tick kind in tdata[1:0]
//   (0 second tick, 1 wave tick, 2 pwm tick, 3 no-op)
// - output stream: one word per input word with the pin levels, the standby
//   flag and the remaining seconds as they stand after that tick
// - configuration: write enable, register index and 16 bit data; registers
//   are light period, sound period, light level, sound level, work seconds;
//   writing work seconds reloads the countdown, other indexes are ignored
// - output: the result is registered in the output register and held there
//   until it is taken
// - throughput: one word per cycle while results are taken; a word is held
//   in the input register and the state advances only when the output
//   register is free or being taken, so a stalled receiver holds the result
//   steady and stops new words one word later
// - reset: pins low, phases and pwm slot at zero, periods 456, levels 10,
//   work time 3600 seconds, standby clear
// - once standby is set it stays set until reset and the pins stay low
module dual_square_wave_with_pwm_gating_core #(
    parameter int unsigned PWM_STEPS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tdata: tick_kind[1:0], zero fill [7:2]
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [dswpg_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tdata: light_pin[0], sound_pin[1], standby[2], seconds_left[18:3],
    // zero fill [23:19]
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [dswpg_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input  logic                             i_cfg_we,
    input  logic [dswpg_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [dswpg_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam logic [dswpg_pkg::SLOT_W-1:0] STEPS = dswpg_pkg::SLOT_W'(PWM_STEPS);

    // configuration
    logic [dswpg_pkg::PERIOD_W-1:0] r_light_period;
    logic [dswpg_pkg::PERIOD_W-1:0] r_sound_period;
    logic [dswpg_pkg::LEVEL_W-1:0]  r_light_level;
    logic [dswpg_pkg::LEVEL_W-1:0]  r_sound_level;

    // input register
    logic             r_in_valid;
    dswpg_pkg::t_kind r_in_kind;

    // state
    logic [dswpg_pkg::SLOT_W-1:0] r_slot;
    logic [dswpg_pkg::SLOT_W-1:0] n_slot;
    logic                         r_light_out;
    logic                         n_light_out;
    logic                         r_sound_out;
    logic                         n_sound_out;
    logic [dswpg_pkg::SECS_W-1:0] r_remaining;
    logic [dswpg_pkg::SECS_W-1:0] n_remaining;
    logic                         r_halted;
    logic                         n_halted;

    // result register
    logic                 r_out_valid;
    dswpg_pkg::t_result   r_out;
    dswpg_pkg::t_result   n_out;

    logic                         w_advance;
    logic                         w_step;
    logic                         w_wave_en;
    logic                         w_light_wave;
    logic                         w_sound_wave;
    logic [dswpg_pkg::SLOT_W-1:0] w_slot_inc;
    logic [dswpg_pkg::SECS_W-1:0] w_rem_dec;
    logic                         w_reload;

    assign w_advance  = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_advance && !r_halted;
    assign w_wave_en  = w_step && (r_in_kind == dswpg_pkg::KIND_WAVE);
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_reload   = i_cfg_we && (i_cfg_addr == dswpg_pkg::REG_WORK_SECONDS);

    dswpg_wave u_light_wave (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_wave_en),
        .i_period (r_light_period),
        .o_wave   (w_light_wave)
    );

    dswpg_wave u_sound_wave (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_wave_en),
        .i_period (r_sound_period),
        .o_wave   (w_sound_wave)
    );

    always_comb begin
        w_slot_inc  = r_slot + dswpg_pkg::SLOT_W'(1);
        w_rem_dec   = r_remaining - dswpg_pkg::SECS_W'(r_remaining != '0);
        n_slot      = r_slot;
        n_light_out = r_light_out;
        n_sound_out = r_sound_out;
        n_remaining = r_remaining;
        n_halted    = r_halted;
        if (w_step) begin
            case (r_in_kind)
                dswpg_pkg::KIND_SECOND: begin
                    n_remaining = w_rem_dec;
                    if (w_rem_dec == '0) begin
                        n_halted    = 1'b1;
                        n_light_out = 1'b0;
                        n_sound_out = 1'b0;
                    end
                end
                dswpg_pkg::KIND_PWM: begin
                    n_light_out = (w_slot_inc <= r_light_level) ? w_light_wave : 1'b0;
                    n_sound_out = (w_slot_inc <= r_sound_level) ? w_sound_wave : 1'b0;
                    n_slot      = (w_slot_inc >= STEPS) ? '0 : w_slot_inc;
                end
                default: begin
                end
            endcase
        end
        if (w_reload) begin
            n_remaining = i_cfg_wdata;
        end
        n_out.light_pin    = n_light_out;
        n_out.sound_pin    = n_sound_out;
        n_out.standby      = n_halted;
        n_out.seconds_left = n_remaining;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_period <= dswpg_pkg::RST_PERIOD;
            r_sound_period <= dswpg_pkg::RST_PERIOD;
            r_light_level  <= dswpg_pkg::RST_LEVEL;
            r_sound_level  <= dswpg_pkg::RST_LEVEL;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dswpg_pkg::REG_LIGHT_PERIOD: r_light_period <= i_cfg_wdata;
                dswpg_pkg::REG_SOUND_PERIOD: r_sound_period <= i_cfg_wdata;
                dswpg_pkg::REG_LIGHT_LEVEL:  r_light_level  <= i_cfg_wdata[dswpg_pkg::LEVEL_W-1:0];
                dswpg_pkg::REG_SOUND_LEVEL:  r_sound_level  <= i_cfg_wdata[dswpg_pkg::LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_in_kind   <= dswpg_pkg::KIND_SECOND;
            r_out_valid <= 1'b0;
            r_slot      <= '0;
            r_light_out <= 1'b0;
            r_sound_out <= 1'b0;
            r_remaining <= dswpg_pkg::RST_SECS;
            r_halted    <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
                r_in_kind  <= dswpg_pkg::t_kind'(i_s_tdata[dswpg_pkg::KIND_W-1:0]);
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            r_slot      <= n_slot;
            r_light_out <= n_light_out;
            r_sound_out <= n_sound_out;
            r_remaining <= n_remaining;
            r_halted    <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(dswpg_pkg::OUT_DATA_W - $bits(dswpg_pkg::t_result)){1'b0}}, r_out};

`ifndef SYNTHESIS
    a_halt_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("standby flag cleared without reset");

    a_halt_pins_low : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (!r_light_out && !r_sound_out))
        else $error("pin driven while in standby");

    a_slot_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < STEPS)
        else $error("pwm slot out of range");

    a_remaining_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_reload && !(w_step && (r_in_kind == dswpg_pkg::KIND_SECOND)))
            |=> $stable(r_remaining))
        else $error("remaining seconds changed without a second tick or reload");

    a_stall_no_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !w_step)
        else $error("state advanced while result stalled");
`endif

endmodule
